// File: rtl/windowed_vertex_dedup_assert.svh
// Assertion macros used by the vertex dedup top level.
`ifndef WINDOWED_VERTEX_DEDUP_ASSERT_SVH
`define WINDOWED_VERTEX_DEDUP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WVD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wvd_pkg.sv
// Package with sizes, beat types and chain link types of the vertex dedup block.
`default_nettype none

package wvd_pkg;

  localparam int WINDOW     = 4096;
  localparam int COUNT_BITS = 24;
  localparam int NCELLS     = 16;

  localparam int ROWS    = WINDOW / NCELLS;
  localparam int LANE_W  = $clog2(NCELLS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int ENTRY_W = $clog2(WINDOW);
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int COORD_W = 32;
  localparam int KEY_W   = 4 * COORD_W;
  localparam int INDEX_W = 24;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Input beat: one vertex position.
  typedef struct packed {
    logic               start_mesh;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic [COORD_W-1:0] pos_w;
  } in_beat_t;

  // Output beat: resolved index.
  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               is_new;
    logic               overflow;
  } out_beat_t;

  // Search token that moves one cell per cycle along the chain.
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [ROW_W-1:0]   row;
    logic               hit;
    logic [ENTRY_W-1:0] hit_idx;
  } link_t;

  // Append request broadcast to all cells.
  typedef struct packed {
    logic              en;
    logic [LANE_W-1:0] lane;
    logic [ROW_W-1:0]  row;
    logic [KEY_W-1:0]  key;
  } wr_t;

endpackage

`default_nettype wire

// File: rtl/wvd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module wvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/wvd_cell.sv
// One search cell: a bank of window entries and one stage of the token chain.
`default_nettype none

module wvd_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [wvd_pkg::LANE_W-1:0]  lane_id,
  input  wire logic [wvd_pkg::KEY_W-1:0]   key,
  input  wire logic [wvd_pkg::FILL_W-1:0]  fill,
  input  wire wvd_pkg::wr_t                wr,
  input  wire wvd_pkg::link_t              link_in,
  output wvd_pkg::link_t                   link_out
);

  wvd_pkg::link_t               tok;
  logic [wvd_pkg::KEY_W-1:0]    rdata;
  logic [wvd_pkg::ENTRY_W-1:0]  entry;
  logic                         entry_live;

  // Entries of this lane live at row-major positions row * NCELLS + lane.
  wvd_ram #(
    .WIDTH (wvd_pkg::KEY_W),
    .DEPTH (wvd_pkg::ROWS)
  ) u_bank (
    .clk   (clk),
    .we    (wr.en && (wr.lane == lane_id)),
    .waddr (wr.row),
    .wdata (wr.key),
    .raddr (link_in.row),
    .rdata (rdata)
  );

  // The token is registered, aligned with the bank read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= link_in;
    end
  end

  // Compare the entry against the key if it lies below the window fill.
  assign entry      = {tok.row, lane_id};
  assign entry_live = ({1'b0, entry} < fill);

  always_comb begin
    link_out = tok;
    if (tok.valid && !tok.hit && entry_live && (rdata == key)) begin
      link_out.hit     = 1'b1;
      link_out.hit_idx = entry;
    end
  end

endmodule

`default_nettype wire

// File: rtl/windowed_vertex_dedup.sv
// Top level of the windowed vertex dedup block: control, key register and cell chain.
//
//   Channel | Signals                    | Beat
//   --------+----------------------------+------------------------------------
//   vtx     | vtx_valid, vtx_ready, vtx  | start_mesh, pos_x, pos_y, pos_z, pos_w
//   idx     | idx_valid, idx_ready, idx  | vertex_index, is_new, overflow
//
// One vertex is handled at a time. A vertex that finds the window empty, or
// that starts a mesh, skips the search and goes straight to the decision.
// Otherwise the search streams ceil(fill / 16) rows of the banked window
// through a chain of 16 cells, one row per cycle, before the decision.
// Reset is synchronous; the window store needs no clearing pass.
// A stalled idx channel holds the next result in its decision step.
`default_nettype none

module windowed_vertex_dedup (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                vtx_valid,
  output logic                     vtx_ready,
  input  wire wvd_pkg::in_beat_t   vtx,
  output logic                     idx_valid,
  input  wire logic                idx_ready,
  output wvd_pkg::out_beat_t       idx
);

  `include "windowed_vertex_dedup_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  state_t                           state;
  logic [wvd_pkg::FILL_W-1:0]       window_fill;
  logic [wvd_pkg::COUNT_BITS-1:0]   unique_count;
  logic [wvd_pkg::KEY_W-1:0]        key;
  logic [wvd_pkg::ROW_W-1:0]        row_cnt;
  logic [wvd_pkg::ROW_W-1:0]        last_row;
  logic                             found;
  logic [wvd_pkg::ENTRY_W-1:0]      found_idx;

  wvd_pkg::link_t                   chain [wvd_pkg::NCELLS+1];
  wvd_pkg::link_t                   tail;
  wvd_pkg::wr_t                     wr;

  logic                             in_fire;
  logic                             dec_fire;
  logic                             dec_append;
  logic                             in_search;
  logic [wvd_pkg::FILL_W-1:0]       fill_m1;
  logic [wvd_pkg::ENTRY_W-1:0]      slot;
  logic [wvd_pkg::COUNT_BITS-1:0]   hit_global;
  logic [wvd_pkg::COUNT_BITS-1:0]   count_inc;

  assign vtx_ready = (state == ST_IDLE);
  assign in_fire   = vtx_valid && vtx_ready;
  assign dec_fire  = (state == ST_DECIDE) && (!idx_valid || idx_ready);
  assign in_search = (state == ST_SEARCH) || (state == ST_WAIT);
  assign fill_m1   = window_fill - wvd_pkg::FILL_W'(1);
  assign count_inc = unique_count + wvd_pkg::COUNT_BITS'(1);
  assign tail      = chain[wvd_pkg::NCELLS];

  // Token issue into the first cell.
  always_comb begin
    chain[0]         = '0;
    chain[0].valid   = (state == ST_SEARCH);
    chain[0].last    = (row_cnt == last_row);
    chain[0].row     = row_cnt;
  end

  // Row of cells.
  for (genvar k = 0; k < wvd_pkg::NCELLS; k++) begin : g_cell
    wvd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .lane_id  (wvd_pkg::LANE_W'(k)),
      .key      (key),
      .fill     (window_fill),
      .wr       (wr),
      .link_in  (chain[k]),
      .link_out (chain[k+1])
    );
  end

  // Decision: match, saturation or append.
  assign dec_append = !found && (unique_count != wvd_pkg::COUNT_MAX);
  assign slot       = (window_fill == wvd_pkg::FILL_W'(wvd_pkg::WINDOW)) ? '0
                      : window_fill[wvd_pkg::ENTRY_W-1:0];
  assign hit_global = unique_count
                      - wvd_pkg::COUNT_BITS'(window_fill)
                      + wvd_pkg::COUNT_BITS'(found_idx);

  always_comb begin
    wr      = '0;
    wr.en   = dec_fire && dec_append;
    wr.lane = slot[wvd_pkg::LANE_W-1:0];
    wr.row  = slot[wvd_pkg::ENTRY_W-1:wvd_pkg::LANE_W];
    wr.key  = key;
  end

  // Control sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_fill  <= '0;
      unique_count <= '0;
      row_cnt      <= '0;
      found        <= 1'b0;
      idx_valid    <= 1'b0;
    end else begin
      // The result is raised by a decision and dropped once its beat is taken.
      if (dec_fire) begin
        idx_valid <= 1'b1;
      end else if (idx_valid && idx_ready) begin
        idx_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            found   <= 1'b0;
            row_cnt <= '0;
            if (vtx.start_mesh) begin
              window_fill  <= '0;
              unique_count <= '0;
              state        <= ST_DECIDE;
            end else if (window_fill == '0) begin
              state <= ST_DECIDE;
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          // Early rows leave the chain while later rows are still issued.
          if (tail.valid && tail.hit) begin
            found <= 1'b1;
          end
          row_cnt <= row_cnt + wvd_pkg::ROW_W'(1);
          if (row_cnt == last_row) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (tail.valid && tail.hit) begin
            found <= 1'b1;
          end
          if (tail.valid && tail.last) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (dec_fire) begin
            state <= ST_IDLE;
            if (dec_append) begin
              window_fill  <= {1'b0, slot} + wvd_pkg::FILL_W'(1);
              unique_count <= count_inc;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Key, search bound and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key      <= {vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.pos_w};
      last_row <= wvd_pkg::ROW_W'(fill_m1[wvd_pkg::FILL_W-1:wvd_pkg::LANE_W]);
    end
    if (in_search && tail.valid && tail.hit) begin
      found_idx <= tail.hit_idx;
    end
    if (dec_fire) begin
      priority if (found) begin
        idx.vertex_index <= wvd_pkg::INDEX_W'(hit_global);
        idx.is_new       <= 1'b0;
        idx.overflow     <= 1'b0;
      end else if (!dec_append) begin
        idx.vertex_index <= wvd_pkg::INDEX_W'(wvd_pkg::COUNT_MAX);
        idx.is_new       <= 1'b0;
        idx.overflow     <= 1'b1;
      end else begin
        idx.vertex_index <= wvd_pkg::INDEX_W'(unique_count);
        idx.is_new       <= 1'b1;
        idx.overflow     <= 1'b0;
      end
    end
  end

  // Tokens leave the chain only while a search is in flight.
  `WVD_ASSERT_NOW(a_exit_in_search, tail.valid, in_search, "token left chain outside a search")
  // The window never holds more entries than it has room for.
  `WVD_ASSERT_NOW(a_fill_bound, 1'b1, window_fill <= wvd_pkg::FILL_W'(wvd_pkg::WINDOW), "fill overrun")
  // An append advances the unique count by one and raises a new-vertex result.
  `WVD_ASSERT_NEXT(a_append, wr.en, idx.is_new && (unique_count == $past(count_inc)), "lost append")

endmodule

`default_nettype wire

// File: tb/windowed_vertex_dedup_tb.sv
// Self-checking testbench for the windowed vertex dedup block.
`default_nettype none

module windowed_vertex_dedup_tb;

  logic               clk;
  logic               rst;
  logic               vtx_valid;
  logic               vtx_ready;
  wvd_pkg::in_beat_t  vtx;
  logic               idx_valid;
  logic               idx_ready;
  wvd_pkg::out_beat_t idx;

  windowed_vertex_dedup dut (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .idx_valid (idx_valid),
    .idx_ready (idx_ready),
    .idx       (idx)
  );

  // Shadow of the block: window keys, window fill and unique count of this mesh.
  logic [wvd_pkg::KEY_W-1:0]      shadow_keys [wvd_pkg::WINDOW];
  int                             shadow_fill;
  logic [wvd_pkg::COUNT_BITS-1:0] shadow_uniques;

  wvd_pkg::out_beat_t index_queue [$];
  int                 failures;
  bit                 idling_on;
  int                 hold_off_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run length guard.
  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Welds one vertex into the shadow window and returns the index it resolves to.
  function automatic wvd_pkg::out_beat_t weld_vertex(input wvd_pkg::in_beat_t v);
    logic [wvd_pkg::KEY_W-1:0] key;
    wvd_pkg::out_beat_t        res;
    bit                        found;
    key   = {v.pos_x, v.pos_y, v.pos_z, v.pos_w};
    res   = '0;
    found = 1'b0;
    if (v.start_mesh) begin
      shadow_fill    = 0;
      shadow_uniques = '0;
    end
    for (int i = 0; i < shadow_fill; i++) begin
      if (!found && shadow_keys[i] == key) begin
        found            = 1'b1;
        res.vertex_index = wvd_pkg::INDEX_W'(longint'(shadow_uniques) - shadow_fill + i);
      end
    end
    if (found) return res;
    // The count limit saturates the index; it takes 2^24 - 1 uniques to get there.
    if (shadow_uniques == wvd_pkg::COUNT_MAX) begin
      res.vertex_index = wvd_pkg::INDEX_W'(wvd_pkg::COUNT_MAX);
      res.overflow     = 1'b1;
      return res;
    end
    // A full window is emptied before the new unique goes in.
    if (shadow_fill >= wvd_pkg::WINDOW) shadow_fill = 0;
    shadow_keys[shadow_fill] = key;
    shadow_fill++;
    res.vertex_index = wvd_pkg::INDEX_W'(shadow_uniques);
    res.is_new       = 1'b1;
    shadow_uniques++;
    return res;
  endfunction

  function automatic wvd_pkg::in_beat_t vertex_beat(input bit start,
                                                    input logic [wvd_pkg::KEY_W-1:0] key);
    wvd_pkg::in_beat_t b;
    b.start_mesh = start;
    {b.pos_x, b.pos_y, b.pos_z, b.pos_w} = key;
    return b;
  endfunction

  function automatic logic [wvd_pkg::KEY_W-1:0] random_key();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Offers one vertex beat, waits for it to be taken, and records its expected index.
  task automatic send_vertex(input wvd_pkg::in_beat_t beat);
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      vtx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vtx       <= beat;
    vtx_valid <= 1'b1;
    do @(posedge clk); while (!vtx_ready);
    index_queue.insert(index_queue.size(), weld_vertex(beat));
  endtask

  // Parks the sender and waits until every expected index has come back.
  task automatic wait_for_results();
    @(negedge clk);
    vtx_valid <= 1'b0;
    while (index_queue.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    int burst;
    idx_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        idx_ready <= 1'b0;
        hold_off_cycles--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 16);
        idx_ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        idx_ready <= 1'b1;
      end
    end
  end

  // Compares each index beat against the oldest expectation.
  always @(posedge clk) begin
    wvd_pkg::out_beat_t want;
    if (!rst && idx_valid && idx_ready) begin
      if (index_queue.size() == 0) begin
        $error("unexpected index beat: vertex_index %0d", idx.vertex_index);
        failures++;
      end else begin
        want = index_queue.pop_front();
        if (idx.vertex_index !== want.vertex_index) begin
          $error("vertex_index: expected %0d, got %0d", want.vertex_index, idx.vertex_index);
          failures++;
        end
        if (idx.is_new !== want.is_new) begin
          $error("is_new: expected %0b, got %0b", want.is_new, idx.is_new);
          failures++;
        end
        if (idx.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, idx.overflow);
          failures++;
        end
      end
    end
  end

  // Field extremes, signed zeros, NaN patterns, one-bit near misses and mesh restarts.
  task automatic test_directed();
    logic [wvd_pkg::KEY_W-1:0] ones;
    logic [wvd_pkg::KEY_W-1:0] nan4;
    ones = '1;
    nan4 = {4{32'h7fc0_0000}};
    send_vertex(vertex_beat(1'b0, '0));
    send_vertex(vertex_beat(1'b0, '0));
    send_vertex(vertex_beat(1'b0, {32'h8000_0000, 96'h0}));
    send_vertex(vertex_beat(1'b0, ones));
    send_vertex(vertex_beat(1'b0, nan4));
    send_vertex(vertex_beat(1'b0, nan4));
    send_vertex(vertex_beat(1'b0, {32'h0, 32'h8000_0000, 64'h0}));
    send_vertex(vertex_beat(1'b0, ones ^ (128'b1 << 127)));
    send_vertex(vertex_beat(1'b0, ones ^ (128'b1 << 64)));
    send_vertex(vertex_beat(1'b0, ones ^ (128'b1 << 63)));
    send_vertex(vertex_beat(1'b0, ones ^ 128'b1));
    send_vertex(vertex_beat(1'b0, ones));
    send_vertex(vertex_beat(1'b0, {32'h8000_0000, 96'h0}));
    // A new mesh forgets everything stored before it.
    send_vertex(vertex_beat(1'b1, ones));
    send_vertex(vertex_beat(1'b0, '0));
    send_vertex(vertex_beat(1'b0, ones));
    send_vertex(vertex_beat(1'b1, '0));
    send_vertex(vertex_beat(1'b1, '0));
    send_vertex(vertex_beat(1'b0, '0));
    wait_for_results();
  endtask

  // Random meshes: repeats from a pool of positions, mixed with fresh keys and noise.
  task automatic test_random_meshes();
    logic [wvd_pkg::KEY_W-1:0] pool [$];
    logic [wvd_pkg::KEY_W-1:0] key;
    int                        sent;
    int                        len;
    int                        pick;
    bit                        start;
    sent = 0;
    while (sent < 1000) begin
      idling_on = ($urandom_range(0, 3) != 0);
      pool.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 60);
      for (int j = 0; j < len; j++) begin
        pick = $urandom_range(0, 9);
        if (pool.size() == 0 || pick < 3) begin
          key = random_key();
          pool.insert(pool.size(), key);
        end else if (pick < 8) begin
          key = pool[$urandom_range(0, pool.size() - 1)];
        end else if (pick == 8) begin
          // Near miss: one bit away from a stored position.
          key = pool[$urandom_range(0, pool.size() - 1)] ^ (128'b1 << $urandom_range(0, 127));
        end else begin
          case ($urandom_range(0, 2))
            0:       key = '0;
            1:       key = '1;
            default: key = {4{32'h8000_0000}};
          endcase
        end
        if (j == 0) start = ($urandom_range(0, 7) != 0);
        else        start = ($urandom_range(0, 99) == 0);
        send_vertex(vertex_beat(start, key));
        sent++;
      end
    end
    wait_for_results();
    idling_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while vertices keep coming.
  task automatic test_output_backpressure();
    logic [wvd_pkg::KEY_W-1:0] key;
    key = random_key();
    hold_off_cycles = 300;
    send_vertex(vertex_beat(1'b1, key));
    send_vertex(vertex_beat(1'b0, random_key()));
    send_vertex(vertex_beat(1'b0, key));
    send_vertex(vertex_beat(1'b0, random_key()));
    send_vertex(vertex_beat(1'b0, key));
    wait_for_results();
  endtask

  // The sender pauses until all indices are back, then the mesh continues.
  task automatic test_sender_pause();
    logic [wvd_pkg::KEY_W-1:0] keep [4];
    for (int i = 0; i < 4; i++) keep[i] = random_key();
    for (int i = 0; i < 4; i++) send_vertex(vertex_beat(i == 0, keep[i]));
    wait_for_results();
    for (int i = 3; i >= 0; i--) send_vertex(vertex_beat(1'b0, keep[i]));
    send_vertex(vertex_beat(1'b0, random_key()));
    wait_for_results();
  endtask

  // Fills the whole window, hits its first and last entries, then wraps it.
  task automatic test_full_window();
    logic [wvd_pkg::KEY_W-1:0] first_key;
    logic [wvd_pkg::KEY_W-1:0] last_key;
    logic [wvd_pkg::KEY_W-1:0] key;
    idling_on = 1'b0;
    for (int i = 0; i < wvd_pkg::WINDOW; i++) begin
      key = {32'(i), $urandom(), $urandom(), $urandom()};
      if (i == 0) first_key = key;
      last_key = key;
      send_vertex(vertex_beat(i == 0, key));
    end
    send_vertex(vertex_beat(1'b0, last_key));
    send_vertex(vertex_beat(1'b0, first_key));
    // A new unique empties the window; old positions then come back as new.
    send_vertex(vertex_beat(1'b0, random_key()));
    send_vertex(vertex_beat(1'b0, first_key));
    send_vertex(vertex_beat(1'b0, last_key));
    send_vertex(vertex_beat(1'b0, first_key));
    wait_for_results();
  endtask

  // Test sequence.
  initial begin
    rst             = 1'b1;
    vtx_valid       = 1'b0;
    vtx             = '0;
    failures        = 0;
    idling_on       = 1'b1;
    hold_off_cycles = 0;
    shadow_fill     = 0;
    shadow_uniques  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_output_backpressure();
    test_sender_pause();
    test_random_meshes();
    test_full_window();

    wait_for_results();
    repeat (300) @(posedge clk);
    if (failures == 0 && index_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
